@@ rtl/core/corner_angle_path_simplifier_assert.svh @@
// Assertion macros used by the checker file of the path simplifier.
`ifndef CORNER_ANGLE_PATH_SIMPLIFIER_ASSERT_SVH
`define CORNER_ANGLE_PATH_SIMPLIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAPS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("corner_angle_path_simplifier assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CAPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("corner_angle_path_simplifier assertion failed");

`endif

@@ rtl/core/caps_pkg.sv @@
// Shared constants, types and the keep-mask function of the path simplifier.
package caps_pkg;

    localparam int MAX_DILATE = 8;
    localparam int COORD_BITS = 16;
    localparam int DELAY_LEN  = MAX_DILATE + 2;
    localparam int MARK_LEN   = 2 * MAX_DILATE + 2;
    localparam int CNT_BITS   = $clog2(DELAY_LEN + 1);
    localparam int STEP_BITS  = 4;
    localparam int LAST_MUL   = 10;
    localparam int LAST_STEP  = 11;
    localparam int CMP_BITS   = 98;

    localparam logic signed [15:0] Q_ONE = 16'sd16384;

    localparam logic CFG_COS_LIMIT = 1'b0;
    localparam logic CFG_DILATE    = 1'b1;

    typedef struct packed {
        logic                 load;
        logic                 calc;
        logic [STEP_BITS-1:0] step;
        logic                 update;
        logic                 drain;
    } caps_cmd_t;

    typedef struct packed {
        logic cnt_ge2;
        logic path_end;
        logic cnt_full;
        logic head_keep;
        logic out_free;
        logic drain_last;
    } caps_sts_t;

    function automatic logic [MARK_LEN-1:0] mark_mask(input logic [CNT_BITS-1:0] slot,
                                                     input logic [3:0] d);
        logic [MARK_LEN-1:0] m;
        logic [4:0]          lo;
        logic [4:0]          hi;
        lo = (slot >= d) ? 5'(slot) - 5'(d) : 5'd0;
        hi = 5'(slot) + 5'(d);
        for (int i = 0; i < MARK_LEN; i++) begin
            m[i] = (5'(i) >= lo) && (5'(i) <= hi);
        end
        return m;
    endfunction

endpackage

@@ rtl/core/caps_datapath.sv @@
// Datapath: point buffer, keep marks, shared multiplier, corner test and output register.
module caps_datapath
    import caps_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_addr,
    input  logic [15:0]            cfg_wdata,
    input  logic signed [COORD_BITS-1:0] s_pos_x,
    input  logic signed [COORD_BITS-1:0] s_pos_y,
    input  logic                   s_path_end,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic signed [COORD_BITS-1:0] m_out_x,
    output logic signed [COORD_BITS-1:0] m_out_y,
    output logic                   m_out_end,
    input  caps_cmd_t              cmd,
    output caps_sts_t              sts
);

    logic signed [15:0] cos_reg;
    logic [3:0]         dil_reg;
    logic [3:0]         d_eff;

    logic signed [COORD_BITS-1:0] px_reg [DELAY_LEN];
    logic signed [COORD_BITS-1:0] py_reg [DELAY_LEN];
    logic [MARK_LEN-1:0] marks_reg, marks_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_inc;
    logic [CNT_BITS-1:0] left_reg;
    logic                flush_reg;
    logic                end_reg;

    logic signed [COORD_BITS-1:0] last1_x_reg, last1_y_reg, last2_x_reg, last2_y_reg;
    logic signed [COORD_BITS-1:0] new_x_reg, new_y_reg;
    logic signed [COORD_BITS:0]   ax_reg, ay_reg, bx_reg, by_reg;

    logic signed [34:0] mul_a, mul_b;
    logic signed [69:0] prod_reg;
    logic [33:0]        a2_reg, b2_reg;
    logic signed [34:0] dot_reg;
    logic [30:0]        c2_reg;
    logic [66:0]        ab_reg;
    logic [66:0]        dsq_reg;
    logic [64:0]        rlo_reg;
    logic [CMP_BITS-1:0] rsq_reg;
    logic [CMP_BITS-1:0] lsq;
    logic [STEP_BITS-1:0] store_op;

    logic degen, corner, r_ge_l, l_ge_r;
    logic head_load;
    logic out_valid_reg;
    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic out_end_reg;

    assign d_eff = (dil_reg > 4'(MAX_DILATE)) ? 4'(MAX_DILATE) : dil_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg <= '0;
            dil_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_COS_LIMIT: cos_reg <= $signed(cfg_wdata);
                CFG_DILATE:    dil_reg <= cfg_wdata[3:0];
                default:       cos_reg <= cos_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg      <= {last1_x_reg[COORD_BITS-1], last1_x_reg}
                         - {last2_x_reg[COORD_BITS-1], last2_x_reg};
            ay_reg      <= {last1_y_reg[COORD_BITS-1], last1_y_reg}
                         - {last2_y_reg[COORD_BITS-1], last2_y_reg};
            bx_reg      <= {s_pos_x[COORD_BITS-1], s_pos_x}
                         - {last1_x_reg[COORD_BITS-1], last1_x_reg};
            by_reg      <= {s_pos_y[COORD_BITS-1], s_pos_y}
                         - {last1_y_reg[COORD_BITS-1], last1_y_reg};
            last2_x_reg <= last1_x_reg;
            last2_y_reg <= last1_y_reg;
            last1_x_reg <= s_pos_x;
            last1_y_reg <= s_pos_y;
            new_x_reg   <= s_pos_x;
            new_y_reg   <= s_pos_y;
            end_reg     <= s_path_end;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.step)
            4'd0:    begin mul_a = 35'(ax_reg);  mul_b = 35'(ax_reg); end
            4'd1:    begin mul_a = 35'(ay_reg);  mul_b = 35'(ay_reg); end
            4'd2:    begin mul_a = 35'(bx_reg);  mul_b = 35'(bx_reg); end
            4'd3:    begin mul_a = 35'(by_reg);  mul_b = 35'(by_reg); end
            4'd4:    begin mul_a = 35'(ax_reg);  mul_b = 35'(bx_reg); end
            4'd5:    begin mul_a = 35'(ay_reg);  mul_b = 35'(by_reg); end
            4'd6:    begin mul_a = 35'(cos_reg); mul_b = 35'(cos_reg); end
            4'd7:    begin
                mul_a = $signed({1'b0, a2_reg});
                mul_b = $signed({1'b0, b2_reg});
            end
            4'd8:    begin mul_a = dot_reg; mul_b = dot_reg; end
            4'd9:    begin
                mul_a = $signed({4'd0, c2_reg});
                mul_b = $signed({1'b0, ab_reg[33:0]});
            end
            4'd10:   begin
                mul_a = $signed({4'd0, c2_reg});
                mul_b = $signed({2'd0, ab_reg[66:34]});
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign store_op = cmd.step - 4'd1;

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            if (cmd.step <= 4'(LAST_MUL)) begin
                prod_reg <= mul_a * mul_b;
            end
            if (cmd.step != 4'd0) begin
                unique case (store_op)
                    4'd0:    a2_reg  <= prod_reg[33:0];
                    4'd1:    a2_reg  <= a2_reg + prod_reg[33:0];
                    4'd2:    b2_reg  <= prod_reg[33:0];
                    4'd3:    b2_reg  <= b2_reg + prod_reg[33:0];
                    4'd4:    dot_reg <= prod_reg[34:0];
                    4'd5:    dot_reg <= dot_reg + prod_reg[34:0];
                    4'd6:    c2_reg  <= prod_reg[30:0];
                    4'd7:    ab_reg  <= prod_reg[66:0];
                    4'd8:    dsq_reg <= prod_reg[66:0];
                    4'd9:    rlo_reg <= prod_reg[64:0];
                    4'd10:   rsq_reg <= {prod_reg[63:0], 34'd0} + CMP_BITS'(rlo_reg);
                    default: rsq_reg <= rsq_reg;
                endcase
            end
        end
    end

    assign lsq    = {3'd0, dsq_reg, 28'd0};
    assign r_ge_l = rsq_reg >= lsq;
    assign l_ge_r = lsq >= rsq_reg;
    assign degen  = (ax_reg == '0 && ay_reg == '0) || (bx_reg == '0 && by_reg == '0);

    always_comb begin
        if (cnt_reg < CNT_BITS'(2)) begin
            corner = 1'b0;
        end else if (degen) begin
            corner = cos_reg >= Q_ONE;
        end else if (cos_reg >= 16'sd0) begin
            corner = (dot_reg <= 35'sd0) || r_ge_l;
        end else begin
            corner = (dot_reg < 35'sd0) && l_ge_r;
        end
    end

    assign cnt_inc = cnt_reg + CNT_BITS'(1);

    always_comb begin
        marks_next = marks_reg;
        if (corner) begin
            marks_next = marks_next | mark_mask(cnt_reg - CNT_BITS'(1), d_eff);
        end
        if (cnt_reg == '0) begin
            marks_next = marks_next | mark_mask('0, d_eff);
        end
        if (end_reg) begin
            marks_next = marks_next | mark_mask(cnt_reg, d_eff);
        end
    end

    assign head_load = cmd.drain && marks_reg[0];

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            px_reg[cnt_reg] <= new_x_reg;
            py_reg[cnt_reg] <= new_y_reg;
        end else if (cmd.drain) begin
            for (int i = 0; i < DELAY_LEN - 1; i++) begin
                px_reg[i] <= px_reg[i+1];
                py_reg[i] <= py_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marks_reg <= '0;
            cnt_reg   <= '0;
            left_reg  <= '0;
            flush_reg <= 1'b0;
        end else if (cmd.update) begin
            marks_reg <= marks_next;
            cnt_reg   <= cnt_inc;
            flush_reg <= end_reg;
            left_reg  <= end_reg ? cnt_inc : CNT_BITS'(1);
        end else if (cmd.drain) begin
            marks_reg <= marks_reg >> 1;
            left_reg  <= left_reg - CNT_BITS'(1);
            if (left_reg == CNT_BITS'(1)) begin
                if (flush_reg) begin
                    marks_reg <= '0;
                    cnt_reg   <= '0;
                end else begin
                    cnt_reg   <= cnt_reg - CNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (head_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (head_load) begin
            out_x_reg   <= px_reg[0];
            out_y_reg   <= py_reg[0];
            out_end_reg <= flush_reg && (left_reg == CNT_BITS'(1));
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_out_x   = out_x_reg;
    assign m_out_y   = out_y_reg;
    assign m_out_end = out_end_reg;

    assign sts.cnt_ge2    = cnt_reg >= CNT_BITS'(2);
    assign sts.path_end   = end_reg;
    assign sts.cnt_full   = cnt_reg == CNT_BITS'(DELAY_LEN - 1);
    assign sts.head_keep  = marks_reg[0];
    assign sts.out_free   = !out_valid_reg || m_ready;
    assign sts.drain_last = left_reg == CNT_BITS'(1);

endmodule

@@ rtl/core/caps_ctrl.sv @@
// Controller state machine that sequences the corner test, the update and the drain.
module caps_ctrl
    import caps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  caps_sts_t sts,
    output caps_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CALC   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_DRAIN  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 drain_go;

    assign drain_go = !sts.head_keep || sts.out_free;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        cmd.step   = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = sts.cnt_ge2 ? ST_CALC : ST_UPDATE;
                end
            end
            ST_CALC: begin
                cmd.calc = 1'b1;
                if (step_reg == STEP_BITS'(LAST_STEP)) begin
                    state_next = ST_UPDATE;
                end else begin
                    step_next = step_reg + STEP_BITS'(1);
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = (sts.path_end || sts.cnt_full) ? ST_DRAIN : ST_IDLE;
            end
            ST_DRAIN: begin
                cmd.drain = drain_go;
                if (drain_go && sts.drain_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

@@ rtl/core/corner_angle_path_simplifier.sv @@
// Top level of the corner-angle path simplifier.
// An item with fewer than two buffered points skips the corner test; any other runs it in
// twelve calculation steps: eleven products on one shared 35 by 35 multiplier and a sum.
// When the point buffer is full the oldest point is moved out before the next item is taken.
// A path end drains every buffered point (up to 10) in order, and waits while the output stalls.
// Synchronous active-low reset clears the keep marks, point count, state and output valid.
module corner_angle_path_simplifier
    import caps_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_addr,
    input  logic [15:0]                  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_pos_x,
    input  logic signed [COORD_BITS-1:0] s_pos_y,
    input  logic                         s_path_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_out_x,
    output logic signed [COORD_BITS-1:0] m_out_y,
    output logic                         m_out_end
);

    caps_cmd_t cmd;
    caps_sts_t sts;

    caps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    caps_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .s_path_end (s_path_end),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_out_x    (m_out_x),
        .m_out_y    (m_out_y),
        .m_out_end  (m_out_end),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

@@ rtl/core/caps_checker.sv @@
// Port-level checker for the path simplifier and its bind to the top level.
`include "corner_angle_path_simplifier_assert.svh"

module caps_checker
    import caps_pkg::*;
(
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [COORD_BITS-1:0] m_out_x,
    input logic signed [COORD_BITS-1:0] m_out_y,
    input logic                         m_out_end
);

    `CAPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_x) && $stable(m_out_y) && $stable(m_out_end))
    `CAPS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `CAPS_ASSERT_NOW(a_load_only_when_busy, aclk, aresetn, $rose(m_valid), !$past(s_ready))

endmodule

bind corner_angle_path_simplifier caps_checker u_caps_checker (.*);

@@ sim/corner_angle_path_simplifier_tb.sv @@
// Self-checking testbench of the corner-angle path simplifier with its own point predictor.
`timescale 1ns / 1ps

module corner_angle_path_simplifier_tb;
    import caps_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } point_rec_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               path_end;
        logic               echo;
    } stim_row_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic                         cfg_addr = CFG_COS_LIMIT;
    logic [15:0]                  cfg_wdata = '0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic signed [COORD_BITS-1:0] s_pos_x = '0;
    logic signed [COORD_BITS-1:0] s_pos_y = '0;
    logic                         s_path_end = 1'b0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic signed [COORD_BITS-1:0] m_out_x;
    logic signed [COORD_BITS-1:0] m_out_y;
    logic                         m_out_end;

    corner_angle_path_simplifier dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 0;
    end

    logic signed [15:0] cos_reg;
    logic [3:0]         dilate_reg;
    logic signed [15:0] buf_x [DELAY_LEN];
    logic signed [15:0] buf_y [DELAY_LEN];
    logic [MARK_LEN-1:0] keep_bits;
    int                 buffered;

    point_rec_t kept_points [$];
    int         mismatches = 0;
    int         items_sent = 0;
    int         points_checked = 0;
    int         paths_sent = 0;
    bit         no_idle = 0;
    bit         long_hold = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic is_sharp_turn(input int pi, input int ci,
                                           input logic signed [15:0] nx,
                                           input logic signed [15:0] ny);
        logic signed [127:0] ax, ay, bx, by, a2, b2, dot, l, lsq, rsq, cb;
        ax = buf_x[ci] - buf_x[pi];
        ay = buf_y[ci] - buf_y[pi];
        bx = nx - buf_x[ci];
        by = ny - buf_y[ci];
        if ((ax == 0 && ay == 0) || (bx == 0 && by == 0))
            return cos_reg >= Q_ONE;
        a2 = ax * ax + ay * ay;
        b2 = bx * bx + by * by;
        dot = ax * bx + ay * by;
        l = dot * 128'sd16384;
        lsq = l * l;
        cb = cos_reg;
        rsq = cb * cb * a2 * b2;
        if (cos_reg >= 0) begin
            if (l <= 0)
                return 1'b1;
            return rsq >= lsq;
        end
        if (l >= 0)
            return 1'b0;
        return lsq >= rsq;
    endfunction

    function automatic void mark_keep(input int slot, input int d);
        for (int s = (slot >= d) ? slot - d : 0; s <= slot + d && s < MARK_LEN; s++)
            keep_bits[s] = 1'b1;
    endfunction

    function automatic void clear_path();
        for (int i = 0; i < DELAY_LEN; i++) begin
            buf_x[i] = '0;
            buf_y[i] = '0;
        end
        keep_bits = '0;
        buffered = 0;
    endfunction

    // Advances the path state by one point and returns the points it releases.
    function automatic void simplify_point(input logic signed [15:0] px,
                                           input logic signed [15:0] py,
                                           input logic pend, ref point_rec_t outs[$]);
        int d, cnt;
        point_rec_t r;
        outs = {};
        d = (dilate_reg > MAX_DILATE) ? MAX_DILATE : dilate_reg;
        cnt = (buffered >= DELAY_LEN) ? DELAY_LEN - 1 : buffered;
        if (cnt >= 2 && is_sharp_turn(cnt - 2, cnt - 1, px, py))
            mark_keep(cnt - 1, d);
        if (cnt == 0)
            mark_keep(0, d);
        buf_x[cnt] = px;
        buf_y[cnt] = py;
        cnt++;
        if (pend) begin
            mark_keep(cnt - 1, d);
            for (int s = 0; s < cnt; s++) begin
                if (keep_bits[s]) begin
                    r.x = buf_x[s];
                    r.y = buf_y[s];
                    r.last = 1'b0;
                    outs = {outs, r};
                end
            end
            if (outs.size() > 0)
                outs[outs.size() - 1].last = 1'b1;
            clear_path();
            return;
        end
        if (cnt == DELAY_LEN) begin
            if (keep_bits[0]) begin
                r.x = buf_x[0];
                r.y = buf_y[0];
                r.last = 1'b0;
                outs = {outs, r};
            end
            for (int s = 0; s + 1 < DELAY_LEN; s++) begin
                buf_x[s] = buf_x[s + 1];
                buf_y[s] = buf_y[s + 1];
            end
            buf_x[DELAY_LEN - 1] = '0;
            buf_y[DELAY_LEN - 1] = '0;
            keep_bits = keep_bits >> 1;
            cnt--;
        end
        buffered = cnt;
    endfunction

    task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
                              input logic pend, input logic echo);
        int gap;
        point_rec_t outs[$];
        point_rec_t r;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_pos_x = px;
        s_pos_y = py;
        s_path_end = pend;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        simplify_point(px, py, pend, outs);
        if (echo) begin
            // A path of one point comes back as it went in.
            r.x = px;
            r.y = py;
            r.last = 1'b1;
            kept_points = {kept_points, r};
        end else begin
            foreach (outs[i])
                kept_points = {kept_points, outs[i]};
        end
        items_sent++;
        if (pend)
            paths_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_results();
        s_valid = 1'b0;
        while (kept_points.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        wait_results();
        repeat (40) @(negedge aclk);
        cfg_addr = idx;
        cfg_wdata = value;
        cfg_wr_en = 1'b1;
        if (idx == CFG_COS_LIMIT)
            cos_reg = value;
        else
            dilate_reg = value[3:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic random_path();
        int len, kind;
        logic signed [15:0] x, y, dx, dy;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
        kind = $urandom_range(0, 3);
        x = 16'($urandom);
        y = 16'($urandom);
        dx = $signed(16'($urandom_range(0, 8))) - 16'sd4;
        dy = $signed(16'($urandom_range(0, 8))) - 16'sd4;
        for (int i = 0; i < len; i++) begin
            send_point(x, y, i == len - 1, 1'b0);
            unique case (kind)
                0: begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end
                1: begin
                    x = x + dx;
                    y = y + dy;
                    if ($urandom_range(0, 3) == 0) begin
                        dx = $signed(16'($urandom_range(0, 8))) - 16'sd4;
                        dy = $signed(16'($urandom_range(0, 8))) - 16'sd4;
                    end
                end
                default: begin
                    x = x + $signed(16'($urandom_range(0, 600))) - 16'sd300;
                    y = y + $signed(16'($urandom_range(0, 600))) - 16'sd300;
                end
            endcase
        end
    endtask

    stim_row_t directed [25] = '{
        '{-16'sd32768, -16'sd32768, 1'b1, 1'b1},
        '{16'sd32767, 16'sd32767, 1'b1, 1'b1},
        '{16'sd0, 16'sd0, 1'b1, 1'b1},
        '{-16'sd32768, 16'sd32767, 1'b0, 1'b0},
        '{16'sd32767, -16'sd32768, 1'b1, 1'b0},
        '{16'sd0, 16'sd0, 1'b0, 1'b0},
        '{16'sd10, 16'sd0, 1'b0, 1'b0},
        '{16'sd10, 16'sd10, 1'b0, 1'b0},
        '{16'sd20, 16'sd10, 1'b1, 1'b0},
        '{16'sd0, 16'sd0, 1'b0, 1'b0},
        '{16'sd5, 16'sd5, 1'b0, 1'b0},
        '{16'sd10, 16'sd10, 1'b1, 1'b0},
        '{16'sd3, 16'sd3, 1'b0, 1'b0},
        '{16'sd3, 16'sd3, 1'b0, 1'b0},
        '{16'sd7, 16'sd1, 1'b0, 1'b0},
        '{16'sd0, 16'sd0, 1'b0, 1'b0},
        '{16'sd9, 16'sd0, 1'b1, 1'b0},
        '{16'sd0, 16'sd0, 1'b0, 1'b0},
        '{16'sd1, 16'sd0, 1'b0, 1'b0},
        '{16'sd2, 16'sd0, 1'b0, 1'b0},
        '{16'sd3, 16'sd0, 1'b0, 1'b0},
        '{16'sd4, 16'sd0, 1'b0, 1'b0},
        '{16'sd5, 16'sd0, 1'b0, 1'b0},
        '{16'sd5, 16'sd5, 1'b0, 1'b0},
        '{16'sd6, 16'sd5, 1'b1, 1'b0}
    };

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (kept_points.size() == 0) begin
                report_mismatch($sformatf("unexpected point (%0d,%0d)", m_out_x, m_out_y));
            end else begin
                point_rec_t e;
                e = kept_points.pop_front();
                points_checked++;
                if (m_out_x !== e.x)
                    report_mismatch($sformatf("out_x %0d, expected %0d", m_out_x, e.x));
                if (m_out_y !== e.y)
                    report_mismatch($sformatf("out_y %0d, expected %0d", m_out_y, e.y));
                if (m_out_end !== e.last)
                    report_mismatch($sformatf("out_end %0b, expected %0b", m_out_end, e.last));
            end
        end
    end

    initial begin
        int w;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_ready = 1'b0;
                repeat (300) @(negedge aclk);
                long_hold = 0;
            end
            w = no_idle ? 0 : $urandom_range(0, 18);
            if (w > 0) begin
                m_ready = 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int waited;
        logic [15:0] cos_set [6];
        logic [3:0]  dil_set [6];
        cos_set = '{16'sd16384, -16'sd16384, 16'sd32767, -16'sd32768, 16'sd11585, -16'sd5793};
        dil_set = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd9};
        cos_reg = '0;
        dilate_reg = '0;
        clear_path();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed[i])
            send_point(directed[i].x, directed[i].y, directed[i].path_end, directed[i].echo);

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_COS_LIMIT, cos_set[ph]);
            write_reg(CFG_DILATE, 16'(dil_set[ph]));
            no_idle = (ph == 2);
            if (ph == 1) begin
                long_hold = 1;
                no_idle = 1;
            end
            while (items_sent < 25 + 13 * (ph + 1))
                random_path();
            no_idle = 0;
            if (ph == 3)
                wait_results();
        end

        wait_results();
        waited = 0;
        while (waited < 40) begin
            @(negedge aclk);
            waited++;
        end
        $display("Sent %0d points in %0d paths over six threshold and dilation settings.",
                 items_sent, paths_sent);
        $display("Checked %0d kept points, %0d mismatches.", points_checked, mismatches);
        if (mismatches == 0 && kept_points.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
